[hw/rtl/fixed_partition_fit_allocator_core_macros.svh]
// Assertion macros used by the checker file of the partition allocator.
// No dependencies; included by bare file name.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define FPFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define FPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

[hw/rtl/fpfa_pkg.sv]
// Shared constants, codes and structures of the fixed-partition allocator.
// No dependencies; imported by the allocator's control, top-level and checker modules.
package fpfa_pkg;

    localparam int MAX_PARTITIONS = 32;
    localparam int SIZE_BITS      = 16;

    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 5;
    localparam int AMOUNT_W   = 16;
    localparam int OWNER_W    = 8;
    localparam int OUT_SIZE_W = 16;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam int ADDR_W = $clog2(MAX_PARTITIONS);
    localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
    localparam int LIM_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int CMP_W  = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
    localparam int WORD_W = SIZE_BITS + OWNER_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } t_fit_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_TAIL,
        ST_FINISH,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] amount;
        logic [OWNER_W-1:0]  requester;
    } t_req;

    typedef struct packed {
        logic                  success;
        logic [SLOT_W-1:0]     chosen_slot;
        logic [OUT_SIZE_W-1:0] slot_size;
        logic [OWNER_W-1:0]    slot_owner;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

[hw/rtl/fpfa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the partition table of the allocator.
module fpfa_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/fpfa_ctrl.sv]
// Command sequencer of the allocator: load, read and the partition scan.
// Depends on fpfa_pkg; drives the table RAM and hands results to the top level.
module fpfa_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_accept,
    input  fpfa_pkg::t_req                 i_req,
    input  logic [fpfa_pkg::MODE_W-1:0]    i_fit_mode,
    input  logic [fpfa_pkg::CNT_W-1:0]     i_limit,
    input  logic                           i_push_ok,
    output logic                           o_busy,
    output logic                           o_push,
    output fpfa_pkg::t_result              o_result,
    output fpfa_pkg::t_ram_req             o_ram,
    input  logic [fpfa_pkg::WORD_W-1:0]    i_ram_rdata
);
    import fpfa_pkg::*;

    t_state                    r_state, n_state;
    t_req                      r_req, n_req;
    logic [MAX_PARTITIONS-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]          r_scan_cnt, n_scan_cnt;
    logic                      r_chk_v, n_chk_v;
    logic [ADDR_W-1:0]         r_chk_idx, n_chk_idx;
    logic                      r_found, n_found;
    logic [ADDR_W-1:0]         r_best_idx, n_best_idx;
    logic [SIZE_BITS-1:0]      r_best_size, n_best_size;
    t_result                   r_res, n_res;

    logic [ADDR_W-1:0]    rd_idx;
    logic                 rd_live;
    logic [SIZE_BITS-1:0] rd_size;
    logic [OWNER_W-1:0]   rd_owner;
    logic                 chk_fits;
    logic                 take;
    logic                 slot_in_table;
    logic                 mode_ok;
    t_ram_req             ram;

    // An entry never written since reset reads as size zero and free.
    always_comb begin
        rd_idx   = (r_state == ST_READ) ? ADDR_W'(r_req.slot) : r_chk_idx;
        rd_live  = r_valid[rd_idx];
        rd_size  = rd_live ? i_ram_rdata[WORD_W-1:OWNER_W] : '0;
        rd_owner = rd_live ? i_ram_rdata[OWNER_W-1:0] : '0;
        chk_fits = CMP_W'(rd_size) >= CMP_W'(r_req.amount);
        take     = r_chk_v && (rd_owner == '0) && chk_fits &&
                   (!r_found ||
                    ((i_fit_mode == FIT_BEST) && (rd_size < r_best_size)) ||
                    ((i_fit_mode == FIT_WORST) && (rd_size >= r_best_size)));
        slot_in_table = int'(i_req.slot) < MAX_PARTITIONS;
        mode_ok  = (i_fit_mode == FIT_FIRST) || (i_fit_mode == FIT_BEST) ||
                   (i_fit_mode == FIT_WORST);
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_valid     = r_valid;
        n_scan_cnt  = r_scan_cnt;
        n_chk_v     = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_size = r_best_size;
        n_res       = r_res;
        ram         = '0;
        o_push      = 1'b0;

        if (take) begin
            n_found     = 1'b1;
            n_best_idx  = r_chk_idx;
            n_best_size = rd_size;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_accept) begin
                    n_req      = i_req;
                    n_found    = 1'b0;
                    n_scan_cnt = '0;
                    n_state    = ST_PUSH;
                    n_res      = '{success: 1'b0, chosen_slot: i_req.slot,
                                   slot_size: '0, slot_owner: '0};
                    unique case (i_req.cmd)
                        CMD_LOAD: begin
                            if (slot_in_table) begin
                                ram.we    = 1'b1;
                                ram.waddr = ADDR_W'(i_req.slot);
                                ram.wdata = {SIZE_BITS'(i_req.amount), OWNER_W'(0)};
                                n_valid[ADDR_W'(i_req.slot)] = 1'b1;
                                n_res.success   = 1'b1;
                                n_res.slot_size = OUT_SIZE_W'(SIZE_BITS'(i_req.amount));
                            end
                        end
                        CMD_READ: begin
                            if (slot_in_table) begin
                                ram.re    = 1'b1;
                                ram.raddr = ADDR_W'(i_req.slot);
                                n_state   = ST_READ;
                            end
                        end
                        CMD_ALLOC: begin
                            n_res.chosen_slot = '0;
                            if ((i_req.requester != '0) && mode_ok && (i_limit != '0)) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_res.success    = 1'b1;
                n_res.slot_size  = OUT_SIZE_W'(rd_size);
                n_res.slot_owner = rd_owner;
                n_state          = ST_PUSH;
            end
            ST_SCAN: begin
                // One table entry read per cycle; its check follows when the registered read data returns.
                ram.re     = 1'b1;
                ram.raddr  = r_scan_cnt[ADDR_W-1:0];
                n_chk_v    = 1'b1;
                n_chk_idx  = r_scan_cnt[ADDR_W-1:0];
                n_scan_cnt = CNT_W'(r_scan_cnt + 1'b1);
                if (CNT_W'(r_scan_cnt + 1'b1) == i_limit) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (r_found) begin
                    ram.we    = 1'b1;
                    ram.waddr = r_best_idx;
                    ram.wdata = {r_best_size, r_req.requester};
                    n_valid[r_best_idx] = 1'b1;
                    n_res = '{success: 1'b1, chosen_slot: SLOT_W'(r_best_idx),
                              slot_size: OUT_SIZE_W'(r_best_size),
                              slot_owner: r_req.requester};
                end
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_push_ok) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_chk_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_chk_v <= n_chk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_scan_cnt  <= n_scan_cnt;
        r_chk_idx   <= n_chk_idx;
        r_found     <= n_found;
        r_best_idx  <= n_best_idx;
        r_best_size <= n_best_size;
        r_res       <= n_res;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_result = r_res;
    assign o_ram    = ram;

endmodule

[hw/rtl/fixed_partition_fit_allocator_core.sv]
// Top level of the fixed-partition allocator: configuration, table RAM and result register.
// Depends on fpfa_pkg, fpfa_ram and fpfa_ctrl.
//
// The block holds a table of fixed partitions, each with a size and an owner, in one
// synchronous RAM, and serves load, allocate and read commands one at a time; every
// command gives exactly one result. An allocate scans the active partitions through the
// RAM's single read port, one partition per cycle, up to the partition count capped at
// the table depth of 32; a refused allocate does not scan. The result waits in an output
// register, so the next command is taken while the previous result is still stalled
// downstream. Configuration writes are taken in any cycle and are meant to arrive only
// while the block is idle.
module fixed_partition_fit_allocator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [fpfa_pkg::CMD_W-1:0]        i_command,
    input  logic [fpfa_pkg::SLOT_W-1:0]       i_slot,
    input  logic [fpfa_pkg::AMOUNT_W-1:0]     i_amount,
    input  logic [fpfa_pkg::OWNER_W-1:0]      i_requester,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_success,
    output logic [fpfa_pkg::SLOT_W-1:0]       o_chosen_slot,
    output logic [fpfa_pkg::OUT_SIZE_W-1:0]   o_slot_size,
    output logic [fpfa_pkg::OWNER_W-1:0]      o_slot_owner,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fpfa_pkg::*;

    logic [MODE_W-1:0]  r_fit_mode, n_fit_mode;
    logic [COUNT_W-1:0] r_part_count, n_part_count;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic [LIM_W-1:0] lim_wide;
    logic [CNT_W-1:0] limit;
    logic             cfg_write;
    logic             in_accept;
    logic             out_take;
    logic             push_ok;
    logic             busy;
    logic             push;
    t_req             req;
    t_result          result;
    t_ram_req         ram;
    logic [WORD_W-1:0] ram_rdata;

    assign cfg_write = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_fit_mode   = r_fit_mode;
        n_part_count = r_part_count;
        if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_FIT_MODE:   n_fit_mode   = i_cfg_data[MODE_W-1:0];
                CFG_PART_COUNT: n_part_count = i_cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    // A count above the table depth scans the whole table.
    always_comb begin
        lim_wide = (LIM_W'(r_part_count) > LIM_W'(MAX_PARTITIONS)) ?
                   LIM_W'(MAX_PARTITIONS) : LIM_W'(r_part_count);
        limit    = CNT_W'(lim_wide);
    end

    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !busy;
    assign req        = '{cmd: i_command, slot: i_slot, amount: i_amount,
                          requester: i_requester};

    assign out_take = r_out_valid && !i_out_stall;
    assign push_ok  = !r_out_valid || out_take;

    always_comb begin
        n_out       = push ? result : r_out;
        n_out_valid = push || (r_out_valid && !out_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode   <= '0;
            r_part_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_fit_mode   <= n_fit_mode;
            r_part_count <= n_part_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    fpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_req       (req),
        .i_fit_mode  (r_fit_mode),
        .i_limit     (limit),
        .i_push_ok   (push_ok),
        .o_busy      (busy),
        .o_push      (push),
        .o_result    (result),
        .o_ram       (ram),
        .i_ram_rdata (ram_rdata)
    );

    fpfa_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (MAX_PARTITIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_success     = r_out.success;
    assign o_chosen_slot = r_out.chosen_slot;
    assign o_slot_size   = r_out.slot_size;
    assign o_slot_owner  = r_out.slot_owner;

endmodule

[hw/rtl/fpfa_checker.sv]
// Port-level checks of the partition allocator, bound to its top level.
// Depends on fpfa_pkg and the allocator assertion macros.
`include "fixed_partition_fit_allocator_core_macros.svh"

module fpfa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_success,
    input logic [fpfa_pkg::SLOT_W-1:0]       o_chosen_slot,
    input logic [fpfa_pkg::OUT_SIZE_W-1:0]   o_slot_size,
    input logic [fpfa_pkg::OWNER_W-1:0]      o_slot_owner
);
    import fpfa_pkg::*;

    // A refused or unusable command never reports a partition's contents.
    `FPFA_ASSERT_IMPLY(a_fail_is_empty, i_clk, i_rst_n, o_out_valid && !o_success, (o_slot_size == '0) && (o_slot_owner == '0))

    // Once a command is taken, the block is busy with it in the next cycle.
    `FPFA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A new result only appears at the end of a command's work.
    `FPFA_ASSERT_IMPLY(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

    `FPFA_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_chosen_slot) && $stable(o_slot_size))

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker u_fpfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_success     (o_success),
    .o_chosen_slot (o_chosen_slot),
    .o_slot_size   (o_slot_size),
    .o_slot_owner  (o_slot_owner)
);

[verif/fixed_partition_fit_allocator_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the fixed-partition fit allocator core.
// Depends on fpfa_pkg and the allocator RTL; keeps its own partition table to predict responses.
module fixed_partition_fit_allocator_core_tb;
    import fpfa_pkg::*;

    localparam int CLK_HALF_NS = 10;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 300;

    // Codes the package leaves unnamed but the interface can still carry.
    localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [CMD_W-1:0]      command;
    logic [SLOT_W-1:0]     slot;
    logic [AMOUNT_W-1:0]   amount;
    logic [OWNER_W-1:0]    requester;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  success;
    logic [SLOT_W-1:0]     chosen_slot;
    logic [OUT_SIZE_W-1:0] slot_size;
    logic [OWNER_W-1:0]    slot_owner;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted state of the block.
    logic [SIZE_BITS-1:0]  part_size [MAX_PARTITIONS];
    logic [OWNER_W-1:0]    part_owner [MAX_PARTITIONS];
    logic [MODE_W-1:0]     fit_mode_q = '0;
    logic [COUNT_W-1:0]    part_count_q = '0;

    t_result awaited_responses[$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    int      rx_hold_left = 0;

    fixed_partition_fit_allocator_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_slot        (slot),
        .i_amount      (amount),
        .i_requester   (requester),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_success     (success),
        .o_chosen_slot (chosen_slot),
        .o_slot_size   (slot_size),
        .o_slot_owner  (slot_owner),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("fixed_partition_fit_allocator_core_tb failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < MAX_PARTITIONS; i++) begin
            part_size[i]  = '0;
            part_owner[i] = '0;
        end
    end

    // Works out the response to one command and updates the predicted table.
    function automatic t_result predict_command(input logic [CMD_W-1:0] cmd,
            input logic [SLOT_W-1:0] idx, input logic [AMOUNT_W-1:0] amt,
            input logic [OWNER_W-1:0] req);
        t_result res;
        int      lim;
        int      pick;
        res = '0;
        res.chosen_slot = idx;
        pick = -1;
        case (cmd)
            CMD_LOAD: begin
                part_size[idx]  = amt[SIZE_BITS-1:0];
                part_owner[idx] = '0;
                res.success     = 1'b1;
                res.slot_size   = part_size[idx];
            end
            CMD_ALLOC: begin
                res.chosen_slot = '0;
                lim = (part_count_q > MAX_PARTITIONS) ? MAX_PARTITIONS : int'(part_count_q);
                for (int i = 0; i < lim; i++) begin
                    // A zero requester is refused outright, as are owned partitions.
                    if (req == '0 || part_owner[i] != '0 || part_size[i] < amt)
                        continue;
                    case (fit_mode_q)
                        FIT_FIRST: if (pick < 0) pick = i;
                        FIT_BEST:  if (pick < 0 || part_size[i] < part_size[pick]) pick = i;
                        FIT_WORST: if (pick < 0 || part_size[i] >= part_size[pick]) pick = i;
                        default: ;
                    endcase
                end
                if (pick >= 0) begin
                    part_owner[pick] = req;
                    res.success      = 1'b1;
                    res.chosen_slot  = SLOT_W'(pick);
                    res.slot_size    = part_size[pick];
                    res.slot_owner   = req;
                end
            end
            CMD_READ: begin
                res.success    = 1'b1;
                res.slot_size  = part_size[idx];
                res.slot_owner = part_owner[idx];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
            input logic [31:0] act_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_val, act_val);
    endtask

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(negedge clk) begin
        if (rx_hold_left > 0) begin
            out_stall = 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            out_stall = ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_result exp_res;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_responses.size() == 0) begin
                report_mismatch("unexpected response, valid", 32'd0, 32'd1);
            end else begin
                exp_res = awaited_responses.pop_front();
                if (success !== exp_res.success)
                    report_mismatch("success", 32'(exp_res.success), 32'(success));
                if (chosen_slot !== exp_res.chosen_slot)
                    report_mismatch("chosen_slot", 32'(exp_res.chosen_slot), 32'(chosen_slot));
                if (slot_size !== exp_res.slot_size)
                    report_mismatch("slot_size", 32'(exp_res.slot_size), 32'(slot_size));
                if (slot_owner !== exp_res.slot_owner)
                    report_mismatch("slot_owner", 32'(exp_res.slot_owner), 32'(slot_owner));
            end
        end
    end

    // Offers one command and records its predicted response once the transaction completes.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] idx,
            input logic [AMOUNT_W-1:0] amt, input logic [OWNER_W-1:0] req);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        command   = cmd;
        slot      = idx;
        amount    = amt;
        requester = req;
        in_valid  = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        awaited_responses.push_back(predict_command(cmd, idx, amt, req));
        items_sent++;
    endtask

    // Drops the input and waits until every response has come back.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited_responses.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_FIT_MODE)
            fit_mode_q = val[MODE_W-1:0];
        else
            part_count_q = val[COUNT_W-1:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setup(input logic [CFG_DATA_W-1:0] mode_word,
            input logic [CFG_DATA_W-1:0] count_word);
        settle();
        cfg_write(CFG_FIT_MODE, mode_word);
        cfg_write(CFG_PART_COUNT, count_word);
    endtask

    function automatic logic [AMOUNT_W-1:0] pick_size(input bit tie_pool);
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        // A narrow pool of sizes makes ties between partitions common.
        if (tie_pool)
            return AMOUNT_W'($urandom_range(6, 1) * 16);
        return AMOUNT_W'($urandom);
    endfunction

    function automatic logic [AMOUNT_W-1:0] pick_request(input int lim);
        int r;
        int s;
        r = $urandom_range(9);
        s = (lim > 0) ? $urandom_range(lim - 1) : 0;
        if (r < 4)
            return part_size[s];
        if (r < 6)
            return AMOUNT_W'(part_size[s] - $urandom_range(3));
        if (r == 6)
            return '0;
        if (r < 9)
            return AMOUNT_W'($urandom_range(120));
        return AMOUNT_W'($urandom);
    endfunction

    function automatic logic [OWNER_W-1:0] pick_requester();
        if ($urandom_range(99) < 3)
            return '0;
        return OWNER_W'($urandom_range(255, 1));
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot(input int lim);
        if (lim > 0 && $urandom_range(9) < 8)
            return SLOT_W'($urandom_range(lim - 1));
        return SLOT_W'($urandom);
    endfunction

    // One round: a fresh policy and count, the partitions loaded, then mixed traffic.
    task automatic run_round();
        int                    r;
        int                    cnt;
        int                    lim;
        int                    n_ops;
        bit                    tie_pool;
        logic [MODE_W-1:0]     mode;
        logic [CFG_DATA_W-1:0] mode_word;
        r = $urandom_range(99);
        if (r < 3)
            cnt = 0;
        else if (r < 5)
            cnt = $urandom_range(63, MAX_PARTITIONS + 1);
        else if (r < 15)
            cnt = MAX_PARTITIONS;
        else if (r < 30)
            cnt = $urandom_range(MAX_PARTITIONS - 1, 9);
        else
            cnt = $urandom_range(8, 1);
        mode = ($urandom_range(99) < 5) ? MODE_UNUSED : MODE_W'($urandom_range(2));
        mode_word = CFG_DATA_W'(mode);
        if ($urandom_range(1))
            mode_word = CFG_DATA_W'(($urandom_range(15) << MODE_W) | mode);
        apply_setup(mode_word, CFG_DATA_W'(cnt));
        lim = (cnt > MAX_PARTITIONS) ? MAX_PARTITIONS : cnt;
        tie_pool = 1'($urandom_range(1));
        for (int s = 0; s < lim; s++) begin
            if ($urandom_range(9) != 0)
                send_item(CMD_LOAD, SLOT_W'(s), pick_size(tie_pool), pick_requester());
        end
        n_ops = lim + $urandom_range(20, 4);
        repeat (n_ops) begin
            r = $urandom_range(99);
            if (r < 55)
                send_item(CMD_ALLOC, SLOT_W'($urandom), pick_request(lim), pick_requester());
            else if (r < 75)
                send_item(CMD_READ, pick_slot(lim), AMOUNT_W'($urandom), pick_requester());
            else if (r < 88)
                send_item(CMD_LOAD, pick_slot(lim), pick_size(tie_pool), pick_requester());
            else
                send_item(CMD_W'($urandom_range(3)), SLOT_W'($urandom), AMOUNT_W'($urandom),
                          OWNER_W'($urandom));
        end
    endtask

    task automatic test_load_read_basics();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(CMD_READ, 5'd0, 16'h0000, 8'h00);
        // With no partitions in use nothing can be granted.
        send_item(CMD_ALLOC, 5'd0, 16'h0000, 8'h01);
        send_item(CMD_LOAD, 5'd31, 16'hFFFF, 8'hFF);
        send_item(CMD_LOAD, 5'd0, 16'h0000, 8'h00);
        send_item(CMD_UNUSED, 5'd21, 16'hAAAA, 8'h55);
        send_item(CMD_READ, 5'd31, 16'h5555, 8'hAA);
    endtask

    task automatic test_fit_policies();
        // A count beyond the table depth is capped to the whole table.
        apply_setup(CFG_DATA_W'(FIT_FIRST), 6'd40);
        send_item(CMD_ALLOC, 5'd0, 16'hFFFF, 8'hFF);
        send_item(CMD_ALLOC, 5'd0, 16'h0000, 8'h80);
        send_item(CMD_ALLOC, 5'd0, 16'h0000, 8'h00);
        send_item(CMD_LOAD, 5'd1, 16'd100, 8'h00);
        send_item(CMD_LOAD, 5'd2, 16'd50, 8'h00);
        send_item(CMD_LOAD, 5'd3, 16'd50, 8'h00);
        send_item(CMD_LOAD, 5'd4, 16'd200, 8'h00);
        send_item(CMD_LOAD, 5'd5, 16'd200, 8'h00);
        apply_setup(CFG_DATA_W'(FIT_BEST), 6'd6);
        send_item(CMD_ALLOC, 5'd0, 16'd40, 8'h02);
        apply_setup(CFG_DATA_W'(FIT_WORST), 6'd6);
        send_item(CMD_ALLOC, 5'd0, 16'd10, 8'h04);
        apply_setup(CFG_DATA_W'(MODE_UNUSED), 6'd6);
        send_item(CMD_ALLOC, 5'd0, 16'h0000, 8'h05);
        // Loads and reads beyond the count still act on the table.
        apply_setup(CFG_DATA_W'(FIT_FIRST), 6'd0);
        send_item(CMD_ALLOC, 5'd0, 16'h0000, 8'h06);
        send_item(CMD_READ, 5'd20, 16'h0000, 8'h00);
        send_item(CMD_LOAD, 5'd20, 16'h5555, 8'h00);
        apply_setup(CFG_DATA_W'(FIT_FIRST), 6'd63);
        send_item(CMD_ALLOC, 5'd0, 16'h5555, 8'h07);
        settle();
    endtask

    // The receiver holds off while the sender keeps offering, so the input backs up.
    task automatic test_output_backpressure();
        apply_setup(CFG_DATA_W'(FIT_FIRST), 6'd4);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int s = 0; s < 4; s++)
            send_item(CMD_LOAD, SLOT_W'(s), AMOUNT_W'(16 * (s + 1)), 8'h00);
        settle();
        @(posedge clk);
        rx_hold_left = HOLD_CYCLES;
        repeat (12) begin
            if ($urandom_range(1))
                send_item(CMD_ALLOC, 5'd0, pick_request(4), pick_requester());
            else
                send_item(CMD_READ, pick_slot(4), AMOUNT_W'($urandom), pick_requester());
        end
        settle();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int target);
        int start_count;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start_count = items_sent;
        while (items_sent - start_count < target)
            run_round();
        settle();
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = CMD_LOAD;
        slot      = '0;
        amount    = '0;
        requester = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FIT_MODE;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_load_read_basics();
        test_fit_policies();
        test_output_backpressure();
        test_random_traffic(31, 73, 620);
        test_random_traffic(73, 31, 620);
        test_random_traffic(0, 0, 620);

        settle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && awaited_responses.size() == 0)
            $display("fixed_partition_fit_allocator_core_tb passed");
        else
            $display("fixed_partition_fit_allocator_core_tb failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fpfa_pkg.sv
hw/rtl/fpfa_ram.sv
hw/rtl/fpfa_ctrl.sv
hw/rtl/fixed_partition_fit_allocator_core.sv
hw/rtl/fpfa_checker.sv
verif/fixed_partition_fit_allocator_core_tb.sv
